// File: rtl/cht_pkg.sv
// Shared types and constants for the chained hash table.
// Depends on nothing; every rtl module imports it.
package cht_pkg;

    localparam int MAX_BUCKETS  = 64;
    localparam int POOL_ENTRIES = 256;
    localparam int BUCKET_W     = 6;
    localparam int ENTRY_W      = 8;
    localparam int LINK_W       = 9;
    localparam int COUNT_W      = 9;
    localparam int CFG_W        = 7;

    localparam logic [LINK_W-1:0] NIL_LINK = 9'd256;
    localparam logic [CFG_W-1:0]  BUCKETS_AT_RESET = 7'd16;

    localparam logic [1:0] KIND_PUT    = 2'd0;
    localparam logic [1:0] KIND_GET    = 2'd1;
    localparam logic [1:0] KIND_REMOVE = 2'd2;

    localparam logic [2:0] ST_INSERTED = 3'd0;
    localparam logic [2:0] ST_UPDATED  = 3'd1;
    localparam logic [2:0] ST_FOUND    = 3'd2;
    localparam logic [2:0] ST_MISSING  = 3'd3;
    localparam logic [2:0] ST_REMOVED  = 3'd4;
    localparam logic [2:0] ST_FULL     = 3'd5;

    // Write request to the entry store
    typedef struct packed {
        logic               key_we;
        logic               value_we;
        logic               next_we;
        logic [ENTRY_W-1:0] addr;
        logic [31:0]        key;
        logic [31:0]        value;
        logic [LINK_W-1:0]  next;
    } entry_wr_t;

    // Write request to the bucket head table
    typedef struct packed {
        logic                we;
        logic [BUCKET_W-1:0] addr;
        logic [LINK_W-1:0]   link;
    } head_wr_t;

endpackage

// File: rtl/cht_mod_unit.sv
// Iterative remainder unit: key magnitude modulo bucket count, four bits a cycle.
// Depends on cht_pkg.
module cht_mod_unit
    import cht_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic [31:0]         mag,
    input  logic [CFG_W-1:0]    divisor,
    output logic                done,
    output logic [BUCKET_W-1:0] rem
);

    logic [31:0]      shift_reg;
    logic [CFG_W-1:0] rem_reg;
    logic [CFG_W-1:0] rem_next;
    logic [3:0]       step_reg;
    logic             busy_reg;

    // Four restoring steps on the running remainder
    always_comb
    begin
        logic [CFG_W-1:0] r;
        r = rem_reg;
        for (int i = 0; i < 4; i++)
        begin
            r = {r[CFG_W-2:0], shift_reg[31-i]};
            if (r >= divisor)
            begin
                r = r - divisor;
            end
        end
        rem_next = r;
    end

    // Advance one digit group per cycle
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            step_reg <= '0;
            done     <= 1'b0;
        end
        else
        begin
            done <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                step_reg <= '0;
            end
            else if (busy_reg)
            begin
                step_reg <= step_reg + 4'd1;
                if (step_reg == 4'd7)
                begin
                    busy_reg <= 1'b0;
                    done     <= 1'b1;
                end
            end
        end
    end

    // Datapath
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            shift_reg <= mag;
            rem_reg   <= '0;
        end
        else if (busy_reg)
        begin
            shift_reg <= {shift_reg[27:0], 4'd0};
            rem_reg   <= rem_next;
        end
    end

    assign rem = rem_reg[BUCKET_W-1:0];

endmodule

// File: rtl/cht_head_table.sv
// Bucket head memory with per-bucket valid bits; empty buckets read as the null link.
// Depends on cht_pkg.
module cht_head_table
    import cht_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                rd_en,
    input  logic [BUCKET_W-1:0] rd_addr,
    output logic [LINK_W-1:0]   rd_link,
    input  head_wr_t            wr
);

    logic [LINK_W-1:0]      mem [MAX_BUCKETS];
    logic [MAX_BUCKETS-1:0] valid_reg;

    // Track which buckets have been written
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (wr.we)
        begin
            valid_reg[wr.addr] <= 1'b1;
        end
    end

    // Write and registered read
    always_ff @(posedge clk)
    begin
        if (wr.we)
        begin
            mem[wr.addr] <= wr.link;
        end
        if (rd_en)
        begin
            rd_link <= valid_reg[rd_addr] ? mem[rd_addr] : NIL_LINK;
        end
    end

endmodule

// File: rtl/cht_entry_ram.sv
// Entry store: key, value and next link per pool entry, separate read and write ports, registered read.
// Depends on cht_pkg.
module cht_entry_ram
    import cht_pkg::*;
(
    input  logic               clk,
    input  logic               rd_en,
    input  logic [ENTRY_W-1:0] rd_addr,
    output logic [31:0]        rd_key,
    output logic [31:0]        rd_value,
    output logic [LINK_W-1:0]  rd_next,
    input  entry_wr_t          wr
);

    logic [31:0]       key_mem   [POOL_ENTRIES];
    logic [31:0]       value_mem [POOL_ENTRIES];
    logic [LINK_W-1:0] next_mem  [POOL_ENTRIES];

    // Field writes and registered read
    always_ff @(posedge clk)
    begin
        if (wr.key_we)
        begin
            key_mem[wr.addr] <= wr.key;
        end
        if (wr.value_we)
        begin
            value_mem[wr.addr] <= wr.value;
        end
        if (wr.next_we)
        begin
            next_mem[wr.addr] <= wr.next;
        end
        if (rd_en)
        begin
            rd_key   <= key_mem[rd_addr];
            rd_value <= value_mem[rd_addr];
            rd_next  <= next_mem[rd_addr];
        end
    end

endmodule

// File: rtl/chained_hash_table.sv
// Top level of the chained hash table: request sequencer and free pool.
// Depends on cht_pkg, cht_mod_unit, cht_head_table and cht_entry_ram.
//
// Usage: one request item (kind, key, data_in) on the input channel gives one
// result item (status, data_out, entry_count) on the output channel. Both
// channels use valid/stall; an item moves when valid is high and stall low.
// The block takes one request at a time; in_stall is high from acceptance
// until the result is loaded into the output register.
// Steps per item: modulo hashing (four key bits a cycle), the bucket head
// read, then a walk over the chain nodes in the entry memory, one node at a
// time, then the update (put of a new key reads the free pool link, remove
// writes two links), and last the loading of the result.
// Reset empties all buckets, sets the bucket count to 16 and the free pool to
// entry 0; untouched pool entries are tracked by a fill count, so no clearing
// pass is needed. When the receiver stalls, the result holds in the output
// register and the block waits with its next result until the slot frees.
// cfg_we writes the bucket count (0 taken as 1, above 64 taken as 64); write
// it only while the block is idle. Entries are not rehashed.
module chained_hash_table
    import cht_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     cfg_we,
    input  logic [CFG_W-1:0]         cfg_wdata,
    input  logic                     in_valid,
    output logic                     in_stall,
    input  logic [1:0]               kind,
    input  logic signed [31:0]       key,
    input  logic signed [31:0]       data_in,
    output logic                     out_valid,
    input  logic                     out_stall,
    output logic [2:0]               status,
    output logic signed [31:0]       data_out,
    output logic [COUNT_W-1:0]       entry_count
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_HASH,
        S_HEAD,
        S_WALK,
        S_ACT,
        S_ALLOC,
        S_REM2,
        S_OUT
    } state_t;

    state_t              state_reg;
    logic [CFG_W-1:0]    buckets_reg;
    logic [1:0]          kind_reg;
    logic [31:0]         key_reg;
    logic [31:0]         val_reg;
    logic [BUCKET_W-1:0] bucket_reg;
    logic [LINK_W-1:0]   cur_reg;
    logic [LINK_W-1:0]   prev_reg;
    logic [LINK_W-1:0]   hit_next_reg;
    logic [31:0]         hit_value_reg;
    logic                found_reg;
    logic [LINK_W-1:0]   head_val_reg;
    logic [LINK_W-1:0]   free_head_reg;
    logic [LINK_W-1:0]   fresh_reg;
    logic [COUNT_W-1:0]  count_reg;
    logic [2:0]          res_status_reg;
    logic [31:0]         res_data_reg;
    logic                out_valid_reg;
    logic [2:0]          status_reg;
    logic [31:0]         data_out_reg;
    logic [COUNT_W-1:0]  entry_count_reg;

    logic                in_accept;
    logic [31:0]         mag;
    logic                hash_done;
    logic [BUCKET_W-1:0] hash_rem;
    logic                head_rd_en;
    logic [LINK_W-1:0]   head_link;
    head_wr_t            head_wr;
    logic                ram_rd_en;
    logic [ENTRY_W-1:0]  ram_rd_addr;
    logic [31:0]         ram_key;
    logic [31:0]         ram_value;
    logic [LINK_W-1:0]   ram_next;
    entry_wr_t           ram_wr;
    logic                key_match;
    logic [LINK_W-1:0]   alloc_next;
    logic                out_free;

    assign in_stall  = (state_reg != S_IDLE);
    assign in_accept = in_valid && !in_stall;
    assign mag       = key[31] ? (32'd0 - key) : key;
    assign key_match = (ram_key == key_reg);
    assign out_free  = !out_valid_reg || !out_stall;
    // An entry never handed out yet links to the one after it
    assign alloc_next = (free_head_reg == fresh_reg) ? (fresh_reg + 9'd1) : ram_next;

    cht_mod_unit u_mod (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (in_accept),
        .mag     (mag),
        .divisor (buckets_reg),
        .done    (hash_done),
        .rem     (hash_rem)
    );

    cht_head_table u_head (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (head_rd_en),
        .rd_addr (hash_rem),
        .rd_link (head_link),
        .wr      (head_wr)
    );

    cht_entry_ram u_ram (
        .clk      (clk),
        .rd_en    (ram_rd_en),
        .rd_addr  (ram_rd_addr),
        .rd_key   (ram_key),
        .rd_value (ram_value),
        .rd_next  (ram_next),
        .wr       (ram_wr)
    );

    // Memory reads and writes for the current step
    always_comb
    begin
        head_rd_en  = 1'b0;
        ram_rd_en   = 1'b0;
        ram_rd_addr = '0;
        head_wr     = '0;
        ram_wr      = '0;
        case (state_reg)
            S_HASH:
            begin
                head_rd_en = hash_done;
            end
            S_HEAD:
            begin
                ram_rd_en   = (head_link != NIL_LINK);
                ram_rd_addr = head_link[ENTRY_W-1:0];
            end
            S_WALK:
            begin
                ram_rd_en   = !key_match && (ram_next != NIL_LINK);
                ram_rd_addr = ram_next[ENTRY_W-1:0];
            end
            S_ACT:
            begin
                if (kind_reg == KIND_PUT)
                begin
                    if (found_reg)
                    begin
                        ram_wr.value_we = 1'b1;
                        ram_wr.addr     = cur_reg[ENTRY_W-1:0];
                        ram_wr.value    = val_reg;
                    end
                    else if (free_head_reg != NIL_LINK)
                    begin
                        ram_rd_en   = 1'b1;
                        ram_rd_addr = free_head_reg[ENTRY_W-1:0];
                    end
                end
                else if (kind_reg == KIND_REMOVE && found_reg)
                begin
                    if (prev_reg != NIL_LINK)
                    begin
                        ram_wr.next_we = 1'b1;
                        ram_wr.addr    = prev_reg[ENTRY_W-1:0];
                        ram_wr.next    = hit_next_reg;
                    end
                    else
                    begin
                        head_wr.we   = 1'b1;
                        head_wr.addr = bucket_reg;
                        head_wr.link = hit_next_reg;
                    end
                end
            end
            S_ALLOC:
            begin
                ram_wr.key_we   = 1'b1;
                ram_wr.value_we = 1'b1;
                ram_wr.next_we  = 1'b1;
                ram_wr.addr     = free_head_reg[ENTRY_W-1:0];
                ram_wr.key      = key_reg;
                ram_wr.value    = val_reg;
                ram_wr.next     = head_val_reg;
                head_wr.we      = 1'b1;
                head_wr.addr    = bucket_reg;
                head_wr.link    = free_head_reg;
            end
            S_REM2:
            begin
                ram_wr.next_we = 1'b1;
                ram_wr.addr    = cur_reg[ENTRY_W-1:0];
                ram_wr.next    = free_head_reg;
            end
            default:
            begin
            end
        endcase
    end

    // Sequencer, pool bookkeeping and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            buckets_reg   <= BUCKETS_AT_RESET;
            free_head_reg <= '0;
            fresh_reg     <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            // Clamp and hold the bucket count
            if (cfg_we)
            begin
                if (cfg_wdata == '0)
                begin
                    buckets_reg <= 7'd1;
                end
                else if (cfg_wdata > 7'(MAX_BUCKETS))
                begin
                    buckets_reg <= 7'(MAX_BUCKETS);
                end
                else
                begin
                    buckets_reg <= cfg_wdata;
                end
            end

            // Drop the result once taken
            if (out_valid_reg && !out_stall && state_reg != S_OUT)
            begin
                out_valid_reg <= 1'b0;
            end

            case (state_reg)
                S_IDLE:
                begin
                    if (in_accept)
                    begin
                        kind_reg  <= kind;
                        key_reg   <= key;
                        val_reg   <= data_in;
                        state_reg <= S_HASH;
                    end
                end
                S_HASH:
                begin
                    if (hash_done)
                    begin
                        bucket_reg <= hash_rem;
                        state_reg  <= S_HEAD;
                    end
                end
                S_HEAD:
                begin
                    head_val_reg <= head_link;
                    cur_reg      <= head_link;
                    prev_reg     <= NIL_LINK;
                    found_reg    <= 1'b0;
                    state_reg    <= (head_link == NIL_LINK) ? S_ACT : S_WALK;
                end
                S_WALK:
                begin
                    if (key_match)
                    begin
                        found_reg     <= 1'b1;
                        hit_next_reg  <= ram_next;
                        hit_value_reg <= ram_value;
                        state_reg     <= S_ACT;
                    end
                    else if (ram_next == NIL_LINK)
                    begin
                        state_reg <= S_ACT;
                    end
                    else
                    begin
                        prev_reg <= cur_reg;
                        cur_reg  <= ram_next;
                    end
                end
                S_ACT:
                begin
                    res_data_reg <= (found_reg && kind_reg != KIND_PUT &&
                                     kind_reg != KIND_REMOVE) ? hit_value_reg : 32'd0;
                    case (kind_reg)
                        KIND_PUT:
                        begin
                            if (found_reg)
                            begin
                                res_status_reg <= ST_UPDATED;
                                state_reg      <= S_OUT;
                            end
                            else if (free_head_reg == NIL_LINK)
                            begin
                                res_status_reg <= ST_FULL;
                                state_reg      <= S_OUT;
                            end
                            else
                            begin
                                state_reg <= S_ALLOC;
                            end
                        end
                        KIND_REMOVE:
                        begin
                            if (found_reg)
                            begin
                                state_reg <= S_REM2;
                            end
                            else
                            begin
                                res_status_reg <= ST_MISSING;
                                state_reg      <= S_OUT;
                            end
                        end
                        default:
                        begin
                            res_status_reg <= found_reg ? ST_FOUND : ST_MISSING;
                            state_reg      <= S_OUT;
                        end
                    endcase
                end
                S_ALLOC:
                begin
                    free_head_reg <= alloc_next;
                    if (free_head_reg == fresh_reg)
                    begin
                        fresh_reg <= fresh_reg + 9'd1;
                    end
                    count_reg      <= count_reg + 9'd1;
                    res_status_reg <= ST_INSERTED;
                    state_reg      <= S_OUT;
                end
                S_REM2:
                begin
                    free_head_reg <= cur_reg;
                    if (count_reg != '0)
                    begin
                        count_reg <= count_reg - 9'd1;
                    end
                    res_status_reg <= ST_REMOVED;
                    state_reg      <= S_OUT;
                end
                S_OUT:
                begin
                    if (out_free)
                    begin
                        out_valid_reg   <= 1'b1;
                        status_reg      <= res_status_reg;
                        data_out_reg    <= res_data_reg;
                        entry_count_reg <= count_reg;
                        state_reg       <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign out_valid   = out_valid_reg;
    assign status      = status_reg;
    assign data_out    = data_out_reg;
    assign entry_count = entry_count_reg;

endmodule
